// ===== sv/fps_pkg.sv =====
package fps_pkg;

  // config register map
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLY_A0  = 3'd0,
    REG_POLY_A2  = 3'd1,
    REG_POLY_A3  = 3'd2,
    REG_POLY_A4  = 3'd3,
    REG_AFFINE_C = 3'd4,
    REG_AFFINE_D = 3'd5,
    REG_AFFINE_E = 3'd6,
    REG_PP       = 3'd7
  } cfg_reg_e;

  localparam logic [31:0] AFFINE_C_RST = 32'h4000_0000;

  localparam int unsigned IMAGE_ROWS_DEF = 2048;
  localparam int unsigned IMAGE_COLS_DEF = 2048;

  // datapath widths
  localparam int unsigned XY_W    = 28;  // x, y at 2^-10
  localparam int unsigned R2_W    = 56;  // r^2 at 2^-20
  localparam int unsigned ROOT_W  = 28;  // r at 2^-10
  localparam int unsigned PROD_W  = 62;  // r^3, r^4 after saturation
  localparam int unsigned Z_W     = 64;
  localparam int unsigned ANG_W   = 24;  // Q.20 angle, signed
  localparam int unsigned OANG_W  = 19;  // Q.16 angle, signed

  localparam logic [PROD_W-1:0] LIM61 = 62'h2000_0000_0000_0000;

  localparam logic signed [ANG_W-1:0]  HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [ANG_W-1:0]  PI_Q20      = 24'sd3294199;
  localparam logic signed [OANG_W-1:0] PI_Q16      = 19'sd205887;

  localparam int unsigned CORDIC_STEPS = 20;
  localparam logic [19:0] ATAN_TAB [CORDIC_STEPS] = '{
    20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451,
    20'd32757,  20'd16383,  20'd8192,   20'd4096,   20'd2048,
    20'd1024,   20'd512,    20'd256,    20'd128,    20'd64,
    20'd32,     20'd16,     20'd8,      20'd4,      20'd2
  };

  // per-pixel sideband that rides next to the math
  typedef struct packed {
    logic                   vld;
    logic [11:0]            row;
    logic [11:0]            col;
    logic [7:0]             blu;
    logic [7:0]             grn;
    logic [7:0]             red;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } side_t;

endpackage

// ===== sv/fisheye_pixel_to_sphere.sv =====
// Fisheye pixel to sphere: one pixel word accepted per cycle, one result word per cycle
// while the output is not stalled. 5 affine/radius stages, 28 square root stages, 10
// polynomial stages (split multipliers), 26 atan2 stages. A stalled output freezes the
// whole pipe; pixels outside the frame or at the principal point are dropped inside the
// pipe. Async active-low reset clears valid bits and loads config defaults
// (affine_c = 1.0, all else zero).
module fisheye_pixel_to_sphere
  import fps_pkg::*;
#(
  parameter int unsigned IMAGE_ROWS = IMAGE_ROWS_DEF,
  parameter int unsigned IMAGE_COLS = IMAGE_COLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // pixel in
  input  logic                 pix_valid_i,
  output logic                 pix_stall_o,
  input  logic [11:0]          pixel_row_i,
  input  logic [11:0]          pixel_col_i,
  input  logic [7:0]           blue_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           red_in_i,
  // sphere point out
  output logic                 sph_valid_o,
  input  logic                 sph_stall_i,
  output logic [17:0]          polar_angle_o,
  output logic signed [18:0]   azimuth_o,
  output logic [11:0]          row_out_o,
  output logic [11:0]          col_out_o,
  output logic [7:0]           blue_out_o,
  output logic [7:0]           green_out_o,
  output logic [7:0]           red_out_o
);

  localparam int unsigned POLY_LAT = 10;  // sqrt out -> z out
  localparam int unsigned R2_LAT   = 4;   // sqrt out -> second multiply rank
  localparam int unsigned MID_LAT  = 38;  // r^2 reg -> z reg
  localparam int unsigned ATAN_LAT = 26;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] a0_q, c_q, d_q, e_q;
  logic [47:0]        a2_q, a3_q, a4_q;
  logic [63:0]        pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q <= '0;
      a2_q <= '0;
      a3_q <= '0;
      a4_q <= '0;
      c_q  <= $signed(AFFINE_C_RST);
      d_q  <= '0;
      e_q  <= '0;
      pp_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLY_A0:  a0_q <= $signed(cfg_data_i[31:0]);
        REG_POLY_A2:  a2_q <= cfg_data_i[47:0];
        REG_POLY_A3:  a3_q <= cfg_data_i[47:0];
        REG_POLY_A4:  a4_q <= cfg_data_i[47:0];
        REG_AFFINE_C: c_q  <= $signed(cfg_data_i[31:0]);
        REG_AFFINE_D: d_q  <= $signed(cfg_data_i[31:0]);
        REG_AFFINE_E: e_q  <= $signed(cfg_data_i[31:0]);
        REG_PP:       pp_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the output register is the last stage; everything moves together
  // ---------------------------------------------------------------------------
  logic en;
  assign en          = !(sph_valid_o && sph_stall_i);
  assign pix_stall_o = !en;

  // ---------------------------------------------------------------------------
  // S1: capture pixel, affine products (32x13 each)
  // ---------------------------------------------------------------------------
  logic                   in_frame;
  logic                   v1_q, v2_q, v3_q, v4_q, v5_q;
  side_t                  s1_q, s2_q, s3_q, s4_q, s5_q;
  logic signed [44:0]     cu_q, dv_q, eu_q;
  logic signed [XY_W-1:0] x_d, y_d;

  assign in_frame = ({1'b0, pixel_row_i} < 13'(IMAGE_ROWS)) &&
                    ({1'b0, pixel_col_i} < 13'(IMAGE_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= pix_valid_i && in_frame;
      v2_q <= v1_q;
      v3_q <= v2_q && ((x_d != '0) || (y_d != '0));  // principal point: no result
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.vld <= 1'b0;
      s1_q.row <= pixel_row_i;
      s1_q.col <= pixel_col_i;
      s1_q.blu <= blue_in_i;
      s1_q.grn <= green_in_i;
      s1_q.red <= red_in_i;
      s1_q.x   <= '0;
      s1_q.y   <= '0;
      cu_q     <= c_q * $signed({1'b0, pixel_row_i});
      dv_q     <= d_q * $signed({1'b0, pixel_col_i});
      eu_q     <= e_q * $signed({1'b0, pixel_row_i});
    end
  end

  // ---------------------------------------------------------------------------
  // S2: x and y accumulators at 2^-30
  // ---------------------------------------------------------------------------
  logic signed [47:0] xacc_d, yacc_d, xacc_q, yacc_q;

  assign xacc_d = 48'(cu_q) + 48'(dv_q) - $signed({2'b0, pp_q[31:0], 14'b0});
  assign yacc_d = 48'(eu_q) + $signed({6'b0, s1_q.col, 30'b0})
                - $signed({2'b0, pp_q[63:32], 14'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q   <= s1_q;
      xacc_q <= xacc_d;
      yacc_q <= yacc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // S3: round half up to 2^-10
  // ---------------------------------------------------------------------------
  logic signed [47:0] xr, yr;
  side_t              s3_d;

  assign xr  = xacc_q + 48'sd524288;
  assign yr  = yacc_q + 48'sd524288;
  assign x_d = xr[47:20];
  assign y_d = yr[47:20];

  always_comb begin
    s3_d   = s2_q;
    s3_d.x = x_d;
    s3_d.y = y_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // S4: squares, S5: r^2 at 2^-20
  // ---------------------------------------------------------------------------
  logic signed [55:0] sqx_q, sqy_q;
  logic [R2_W-1:0]    r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q  <= s3_q;
      sqx_q <= s3_q.x * s3_q.x;
      sqy_q <= s3_q.y * s3_q.y;
      s5_q  <= s4_q;
      r2_q  <= R2_W'(sqx_q) + R2_W'(sqy_q);
    end
  end

  side_t s5_side, mid_side, out_side;

  always_comb begin
    s5_side     = s5_q;
    s5_side.vld = v5_q;
  end

  fps_delay #(.W($bits(side_t)), .N(MID_LAT)) u_dly_mid (
    .clk_i, .rst_ni, .en_i(en), .d_i(s5_side), .q_o(mid_side)
  );

  // ---------------------------------------------------------------------------
  // Square root: r at 2^-10
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0] root;
  logic [R2_W-1:0]   r2_s;

  fps_isqrt #(.W(R2_W)) u_sqrt (
    .clk_i, .en_i(en), .val_i(r2_q), .root_o(root), .val_o(r2_s)
  );

  logic [ROOT_W-1:0] root_z;
  logic [R2_W-1:0]   r2_m;

  fps_delay #(.W(ROOT_W), .N(POLY_LAT)) u_dly_root (
    .clk_i, .rst_ni, .en_i(en), .d_i(root), .q_o(root_z)
  );

  fps_delay #(.W(R2_W), .N(R2_LAT)) u_dly_r2 (
    .clk_i, .rst_ni, .en_i(en), .d_i(r2_s), .q_o(r2_m)
  );

  // ---------------------------------------------------------------------------
  // Powers: r^3 at 2^-8 and r^4 at 2^0, saturated at 2^61
  // ---------------------------------------------------------------------------
  logic [R2_W+ROOT_W-1:0] p3_raw;
  logic [2*R2_W-1:0]      p4_raw;
  logic [PROD_W-1:0]      p3_q, p4_q;

  fps_mul #(.WA(R2_W), .WB(ROOT_W)) u_mul_p3 (
    .clk_i, .en_i(en), .a_i(r2_s), .b_i(root), .p_o(p3_raw)
  );

  fps_mul #(.WA(R2_W), .WB(R2_W)) u_mul_p4 (
    .clk_i, .en_i(en), .a_i(r2_s), .b_i(r2_s), .p_o(p4_raw)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q <= (p3_raw[83:22] > LIM61) ? LIM61 : p3_raw[83:22];
      p4_q <= (p4_raw[111:40] > 72'(LIM61)) ? LIM61 : p4_raw[101:40];
    end
  end

  // ---------------------------------------------------------------------------
  // Polynomial terms on magnitudes, sign applied after truncation.
  // Operand ranges keep these below 2^61, so no clamp is needed here.
  // ---------------------------------------------------------------------------
  logic [47:0]  a2_mag, a3_mag, a4_mag;
  logic [103:0] m2;
  logic [109:0] m3, m4;

  assign a2_mag = a2_q[47] ? (~a2_q + 48'd1) : a2_q;
  assign a3_mag = a3_q[47] ? (~a3_q + 48'd1) : a3_q;
  assign a4_mag = a4_q[47] ? (~a4_q + 48'd1) : a4_q;

  fps_mul #(.WA(48), .WB(R2_W)) u_mul_t2 (
    .clk_i, .en_i(en), .a_i(a2_mag), .b_i(r2_m), .p_o(m2)
  );

  fps_mul #(.WA(48), .WB(PROD_W)) u_mul_t3 (
    .clk_i, .en_i(en), .a_i(a3_mag), .b_i(p3_q), .p_o(m3)
  );

  fps_mul #(.WA(48), .WB(PROD_W)) u_mul_t4 (
    .clk_i, .en_i(en), .a_i(a4_mag), .b_i(p4_q), .p_o(m4)
  );

  logic signed [Z_W-1:0] t2_q, t3_q, t4_q, za_q, zb_q, z_q;
  logic signed [Z_W-1:0] q2, q3, q4;

  assign q2 = $signed(Z_W'(m2[103:48]));
  assign q3 = $signed(Z_W'(m3[109:52]));
  assign q4 = $signed(Z_W'(m4[109:60]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_q <= a2_q[47] ? -q2 : q2;
      t3_q <= a3_q[47] ? -q3 : q3;
      t4_q <= a4_q[47] ? -q4 : q4;
      za_q <= t2_q + t3_q;
      zb_q <= t4_q + Z_W'(a0_q);
      z_q  <= za_q + zb_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Angles: theta = atan2(4r, z), phi = atan2(y, x)
  // ---------------------------------------------------------------------------
  logic signed [Z_W-1:0]    r4;
  logic signed [OANG_W-1:0] theta, phi;

  assign r4 = $signed({34'b0, root_z, 2'b0});

  fps_atan2 #(.W(Z_W)) u_atan_theta (
    .clk_i, .en_i(en), .yy_i(r4), .xx_i(z_q), .ang_o(theta)
  );

  fps_atan2 #(.W(XY_W)) u_atan_phi (
    .clk_i, .en_i(en), .yy_i(mid_side.y), .xx_i(mid_side.x), .ang_o(phi)
  );

  fps_delay #(.W($bits(side_t)), .N(ATAN_LAT)) u_dly_out (
    .clk_i, .rst_ni, .en_i(en), .d_i(mid_side), .q_o(out_side)
  );

  // ---------------------------------------------------------------------------
  // Outputs (all straight from registers)
  // ---------------------------------------------------------------------------
  assign sph_valid_o   = out_side.vld;
  assign polar_angle_o = theta[17:0];
  assign azimuth_o     = phi;
  assign row_out_o     = out_side.row;
  assign col_out_o     = out_side.col;
  assign blue_out_o    = out_side.blu;
  assign green_out_o   = out_side.grn;
  assign red_out_o     = out_side.red;

endmodule

// ===== sv/fps_delay.sv =====
module fps_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] dly_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) dly_q[i] <= '0;
    end else if (en_i) begin
      dly_q[0] <= d_i;
      for (int i = 1; i < N; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign q_o = dly_q[N-1];

endmodule

// ===== sv/fps_mul.sv =====
// unsigned multiply split into four partial products; products, sums and result are registered in turn
module fps_mul #(
  parameter int unsigned WA = 56,
  parameter int unsigned WB = 56
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  output logic [WA+WB-1:0] p_o
);

  localparam int unsigned HA = (WA + 1) / 2;
  localparam int unsigned HB = (WB + 1) / 2;
  localparam int unsigned PW = WA + WB;

  logic [HA-1:0]    al;
  logic [WA-HA-1:0] ah;
  logic [HB-1:0]    bl;
  logic [WB-HB-1:0] bh;

  logic [HA+HB-1:0]       p0_q;
  logic [HA+WB-HB-1:0]    p1_q;
  logic [WA-HA+HB-1:0]    p2_q;
  logic [WA-HA+WB-HB-1:0] p3_q;
  logic [PW-1:0]          sa_q, sb_q, p_q;

  assign al = a_i[HA-1:0];
  assign ah = a_i[WA-1:HA];
  assign bl = b_i[HB-1:0];
  assign bh = b_i[WB-1:HB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= al * bl;
      p1_q <= al * bh;
      p2_q <= ah * bl;
      p3_q <= ah * bh;
      // high and low products do not overlap: concatenate
      sa_q <= {p3_q, p0_q};
      sb_q <= (PW'(p1_q) << HB) + (PW'(p2_q) << HA);
      p_q  <= sa_q + sb_q;
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/fps_isqrt.sv =====
// one result bit per stage; value passes alongside
module fps_isqrt #(
  parameter int unsigned W = 56
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   val_i,
  output logic [W/2-1:0] root_o,
  output logic [W-1:0]   val_o
);

  localparam int unsigned STEPS = W / 2;

  logic [W:0]   n_q   [STEPS];
  logic [W:0]   res_q [STEPS];
  logic [W-1:0] val_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2*i);
    logic [W:0]   n_in, res_in, n_d, res_d, trial;
    logic [W-1:0] v_in;

    if (i == 0) begin : g_first
      assign n_in   = {1'b0, val_i};
      assign res_in = '0;
      assign v_in   = val_i;
    end else begin : g_next
      assign n_in   = n_q[i-1];
      assign res_in = res_q[i-1];
      assign v_in   = val_q[i-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (n_in >= trial) begin
        n_d   = n_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        n_d   = n_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i]   <= n_d;
        res_q[i] <= res_d;
        val_q[i] <= v_in;
      end
    end
  end

  assign root_o = res_q[STEPS-1][W/2-1:0];
  assign val_o  = val_q[STEPS-1];

endmodule

// ===== sv/fps_atan2.sv =====
// atan2 in Q.16: abs, 3 normalize stages, 20 CORDIC stages, 2 finish stages
module fps_atan2
  import fps_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [W-1:0]      yy_i,
  input  logic signed [W-1:0]      xx_i,
  output logic signed [OANG_W-1:0] ang_o
);

  localparam int unsigned NORM = 3;
  localparam int unsigned CW   = 33;

  typedef struct packed {
    logic sx;
    logic sy;
    logic zr;
  } flag_t;

  // abs stage
  logic [W-1:0] ax_q, ay_q;
  flag_t        fa_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= xx_i[W-1] ? W'(-xx_i) : W'(xx_i);
      ay_q   <= yy_i[W-1] ? W'(-yy_i) : W'(yy_i);
      fa_q.sx <= xx_i[W-1];
      fa_q.sy <= yy_i[W-1];
      fa_q.zr <= (xx_i == '0) && (yy_i == '0);
    end
  end

  // normalize: shift both right until below 2^30, two shift sizes per stage
  logic [W-1:0] nx_q [NORM];
  logic [W-1:0] ny_q [NORM];
  flag_t        fn_q [NORM];

  for (genvar j = 0; j < NORM; j++) begin : g_norm
    localparam int unsigned K1 = 1 << (5 - 2*j);
    localparam int unsigned K2 = 1 << (4 - 2*j);
    logic [W-1:0] xi, yi, x1, y1, x2, y2;
    flag_t        fi;

    if (j == 0) begin : g_first
      assign xi = ax_q;
      assign yi = ay_q;
      assign fi = fa_q;
    end else begin : g_next
      assign xi = nx_q[j-1];
      assign yi = ny_q[j-1];
      assign fi = fn_q[j-1];
    end

    always_comb begin
      x1 = xi;
      y1 = yi;
      if (((xi | yi) >> (29 + K1)) != '0) begin
        x1 = xi >> K1;
        y1 = yi >> K1;
      end
      x2 = x1;
      y2 = y1;
      if (((x1 | y1) >> (29 + K2)) != '0) begin
        x2 = x1 >> K2;
        y2 = y1 >> K2;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[j] <= x2;
        ny_q[j] <= y2;
        fn_q[j] <= fi;
      end
    end
  end

  // CORDIC vectoring, first quadrant
  logic signed [CW-1:0]    cx_q [CORDIC_STEPS];
  logic signed [CW-1:0]    cy_q [CORDIC_STEPS];
  logic signed [ANG_W-1:0] ca_q [CORDIC_STEPS];
  flag_t                   fc_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0]    xi, yi, dx, dy;
    logic signed [ANG_W-1:0] ai, tab;
    flag_t                   fi;

    if (i == 0) begin : g_first
      assign xi = $signed(CW'(nx_q[NORM-1]));
      assign yi = $signed(CW'(ny_q[NORM-1]));
      assign ai = '0;
      assign fi = fn_q[NORM-1];
    end else begin : g_next
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign ai = ca_q[i-1];
      assign fi = fc_q[i-1];
    end

    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign tab = $signed(ANG_W'(ATAN_TAB[i]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!yi[CW-1]) begin
          cx_q[i] <= xi + dx;
          cy_q[i] <= yi - dy;
          ca_q[i] <= ai + tab;
        end else begin
          cx_q[i] <= xi - dx;
          cy_q[i] <= yi + dy;
          ca_q[i] <= ai - tab;
        end
        fc_q[i] <= fi;
      end
    end
  end

  // finish: clamp, quadrant fix, then round to Q.16
  logic signed [ANG_W-1:0]  a_raw, a_cl, a_mir, a_fin;
  logic signed [ANG_W-1:0]  af_q;
  logic signed [ANG_W-1:0]  rnd;
  logic signed [OANG_W-1:0] q_d, q_q;
  flag_t                    fl;

  assign a_raw = ca_q[CORDIC_STEPS-1];
  assign fl    = fc_q[CORDIC_STEPS-1];

  always_comb begin
    if (a_raw < 0)                a_cl = '0;
    else if (a_raw > HALF_PI_Q20) a_cl = HALF_PI_Q20;
    else                          a_cl = a_raw;
    a_mir = fl.sx ? (PI_Q20 - a_cl) : a_cl;
    a_fin = fl.sy ? -a_mir : a_mir;
    if (fl.zr) a_fin = '0;
  end

  always_comb begin
    rnd = (af_q + ANG_W'(8)) >>> 4;
    if (rnd < ANG_W'(-PI_Q16))    q_d = -PI_Q16;
    else if (rnd > ANG_W'(PI_Q16)) q_d = PI_Q16;
    else                          q_d = rnd[OANG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      af_q <= a_fin;
      q_q  <= q_d;
    end
  end

  assign ang_o = q_q;

endmodule
